// File: rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int NIBBLE_W    = 4;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam logic [NIBBLE_W-1:0] RESET_FG   = 4'hF;
  localparam logic [NIBBLE_W-1:0] RESET_BG   = 4'h0;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [APB_ADDR_W-3:0] REG_FG = 1'd0;
  localparam logic [APB_ADDR_W-3:0] REG_BG = 1'd1;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_color;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } result_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// File: rtl/text_console_writer_top.sv
// Text console writer over an 80x25 screen of character/attribute cells.
// Items arrive on the item channel (item_valid, item_stall, item) and one
// result per item leaves on the result channel (result_valid, result_stall,
// result). A transfer happens on a rising edge with valid high and stall low.
// Opcodes: put character (10 is newline), clear screen, read one cell.
// Colours are set through the APB port: fg_color at 0x0, bg_color at 0x4.
// A two-entry queue takes items while the executor is busy.
// Newline, clear, no-op and reads of a blank row load the result from
// S_IDLE; a put passes through S_PUT and a stored-cell read through S_READ.
// A put into a row that was blanked by clear, scroll or reset first sweeps
// the row into the screen RAM, one cell per cycle, once per row.
// Scrolling rotates a top-row offset and costs nothing further.
// Reset is synchronous: cursor to 0,0, colours white on black, every row
// marked blank with attribute 0x0F; no clearing pass is needed.
// A stalled result holds in the output register; the queue keeps taking
// items until it is full, then item_stall rises.
module text_console_writer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  tcw_pkg::item_t                  item,
  input  logic                            item_valid,
  output logic                            item_stall,
  output tcw_pkg::result_t                result,
  output logic                            result_valid,
  input  logic                            result_stall,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tcw_pkg::*;

  logic [NIBBLE_W-1:0]   fg_color;
  logic [NIBBLE_W-1:0]   bg_color;
  logic [APB_ADDR_W-3:0] reg_index;
  logic                  cfg_write;
  cmd_t                  head;
  logic                  head_valid;
  logic                  pop;
  ram_req_t              ram_req;
  logic [CELL_W-1:0]     ram_rdata;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= RESET_FG;
      bg_color <= RESET_BG;
    end else if (cfg_write) begin
      if (reg_index == REG_FG) begin
        fg_color <= pwdata[NIBBLE_W-1:0];
      end else if (reg_index == REG_BG) begin
        bg_color <= pwdata[NIBBLE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_FG) begin
      prdata = APB_DATA_W'(fg_color);
    end else if (reg_index == REG_BG) begin
      prdata = APB_DATA_W'(bg_color);
    end
  end

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .attr         ({bg_color, fg_color}),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcw_front.sv
module tcw_front (
  input  logic           clk,
  input  logic           rst,
  input  tcw_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_stall,
  output tcw_pkg::cmd_t  head,
  output logic           head_valid,
  input  logic           pop
);
  import tcw_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              cmd;
  logic              push;

  always_comb begin
    cmd.kind      = CMD_NOP;
    cmd.char_code = item.char_code;
    cmd.row       = item.read_row;
    cmd.col       = item.read_col;
    case (item.opcode)
      OP_PUT: begin
        cmd.kind = (item.char_code == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      OP_READ: begin
        if (int'(item.read_row) < ROWS && int'(item.read_col) < COLUMNS) begin
          cmd.kind = CMD_READ;
        end
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  assign item_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tcw_back.sv
module tcw_back (
  input  logic                      clk,
  input  logic                      rst,
  input  tcw_pkg::cmd_t             head,
  input  logic                      head_valid,
  output logic                      pop,
  input  logic [tcw_pkg::ATTR_W-1:0] attr,
  output tcw_pkg::ram_req_t         ram_req,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata,
  output tcw_pkg::result_t          result,
  output logic                      result_valid,
  input  logic                      result_stall
);
  import tcw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUT  = 4'b0010,
    S_FILL = 4'b0100,
    S_READ = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  top, top_next;
  logic [COL_W-1:0]  fill_col, fill_col_next;
  logic [CHAR_W-1:0] put_char;
  logic              row_blank [ROWS];
  logic [ATTR_W-1:0] row_attr [ROWS];
  logic [ROW_W-1:0]  idx;
  logic [ROW_W-1:0]  nl_row;
  logic [ROW_W-1:0]  nl_top;
  logic              nl_scroll;
  logic              scroll;
  logic              clear;
  logic              fill_done;
  logic              load;
  logic              pop_ok;
  result_t           res_next;

  function automatic logic [ROW_W-1:0] phys_of(input logic [ROW_W-1:0] l,
                                               input logic [ROW_W-1:0] t);
    logic [ROW_W:0] s;
    s = {1'b0, l} + {1'b0, t};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  assign pop_ok = (state == S_IDLE) && head_valid && (!result_valid || !result_stall);
  assign pop    = pop_ok;
  assign idx    = (state == S_IDLE) ? phys_of(head.row, top) : phys_of(row, top);

  always_comb begin
    nl_row    = row;
    nl_top    = top;
    nl_scroll = 1'b0;
    if (int'(row) < ROWS - 1) begin
      nl_row = row + 1'b1;
    end else begin
      nl_scroll = 1'b1;
      nl_top    = (int'(top) == ROWS - 1) ? '0 : top + 1'b1;
    end
  end

  always_comb begin
    state_next    = state;
    row_next      = row;
    col_next      = col;
    top_next      = top;
    fill_col_next = fill_col;
    scroll        = 1'b0;
    clear         = 1'b0;
    fill_done     = 1'b0;
    load          = 1'b0;
    ram_req       = '0;
    res_next      = '0;
    res_next.cursor_row = row;
    res_next.cursor_col = col;
    case (state)
      S_IDLE: begin
        ram_req.raddr = addr_of(idx, head.col);
        if (pop_ok) begin
          case (head.kind)
            CMD_PUT: begin
              if (int'(col) >= COLUMNS) begin
                col_next = '0;
                row_next = nl_row;
                top_next = nl_top;
                scroll   = nl_scroll;
              end
              state_next = S_PUT;
            end
            CMD_NEWLINE: begin
              col_next = '0;
              row_next = nl_row;
              top_next = nl_top;
              scroll   = nl_scroll;
              load     = 1'b1;
              res_next.cursor_row = nl_row;
              res_next.cursor_col = '0;
            end
            CMD_CLEAR: begin
              clear = 1'b1;
              load  = 1'b1;
            end
            CMD_READ: begin
              if (row_blank[idx]) begin
                load = 1'b1;
                res_next.cell_char  = BLANK_CHAR;
                res_next.cell_color = row_attr[idx];
              end else begin
                state_next = S_READ;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_PUT: begin
        if (row_blank[idx]) begin
          fill_col_next = '0;
          state_next    = S_FILL;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = addr_of(idx, col);
          ram_req.wdata = {attr, put_char};
          col_next      = col + 1'b1;
          load          = 1'b1;
          res_next.cursor_col = col + 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_of(idx, fill_col);
        ram_req.wdata = {row_attr[idx], BLANK_CHAR};
        fill_col_next = fill_col + 1'b1;
        if (int'(fill_col) == COLUMNS - 1) begin
          fill_done  = 1'b1;
          state_next = S_PUT;
        end
      end
      S_READ: begin
        load = 1'b1;
        res_next.cell_char  = ram_rdata[CHAR_W-1:0];
        res_next.cell_color = ram_rdata[CELL_W-1:CHAR_W];
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop_ok) begin
      put_char <= head.char_code;
    end
    if (load) begin
      result <= res_next;
    end
    fill_col <= fill_col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row          <= '0;
      col          <= '0;
      top          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      top   <= top_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        row_blank[r] <= 1'b1;
        row_attr[r]  <= RESET_ATTR;
      end
    end else if (clear) begin
      for (int r = 0; r < ROWS; r++) begin
        row_blank[r] <= 1'b1;
        row_attr[r]  <= attr;
      end
    end else if (scroll) begin
      row_blank[top] <= 1'b1;
      row_attr[top]  <= attr;
    end else if (fill_done) begin
      row_blank[idx] <= 1'b0;
    end
  end

endmodule

// File: bench/text_console_checker.sv
module text_console_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  tcw_pkg::item_t                  item,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  tcw_pkg::result_t                result,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
  output int                              mismatches,
  output int                              pending,
  output int                              items_seen,
  output int                              results_seen,
  output int                              scrolls,
  output int                              wraps
);

  import tcw_pkg::*;

  logic [CELL_W-1:0]   screen [CELLS];
  logic [ROW_W-1:0]    row_now;
  logic [COL_W-1:0]    col_now;
  logic [NIBBLE_W-1:0] fg;
  logic [NIBBLE_W-1:0] bg;
  result_t             awaited_q [$];
  int                  errs;
  int                  items_n;
  int                  results_n;
  int                  scroll_n;
  int                  wrap_n;

  function automatic logic [ATTR_W-1:0] attr_now();
    return {bg, fg};
  endfunction

  task automatic blank_row(input int r, input logic [ATTR_W-1:0] a);
    for (int x = 0; x < COLUMNS; x++) screen[r*COLUMNS + x] = {a, BLANK_CHAR};
  endtask

  task automatic line_feed();
    col_now = '0;
    if (row_now < ROWS - 1) begin
      row_now = row_now + 1'b1;
    end else begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      blank_row(ROWS - 1, attr_now());
      scroll_n++;
    end
  endtask

  task automatic console_step(input item_t it, output result_t r);
    logic [CELL_W-1:0] c;
    c = '0;
    case (it.opcode)
      OP_PUT: begin
        if (it.char_code == NEWLINE_CHAR) begin
          line_feed();
        end else begin
          if (col_now >= COLUMNS) begin
            line_feed();
            wrap_n++;
          end
          screen[row_now*COLUMNS + col_now] = {attr_now(), it.char_code};
          col_now = col_now + 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int y = 0; y < ROWS; y++) blank_row(y, attr_now());
      end
      OP_READ: begin
        if (it.read_row < ROWS && it.read_col < COLUMNS)
          c = screen[it.read_row*COLUMNS + it.read_col];
      end
      default: ;
    endcase
    r.cell_char  = c[CHAR_W-1:0];
    r.cell_color = c[CELL_W-1:CHAR_W];
    r.cursor_row = row_now;
    r.cursor_col = col_now;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (awaited_q.size() == 0) begin
      $error("result transfer with nothing outstanding: %p", got);
      errs++;
    end else begin
      want = awaited_q.pop_front();
      check_field("cell_char", want.cell_char, got.cell_char);
      check_field("cell_color", want.cell_color, got.cell_color);
      check_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
      check_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
    end
  endtask

  always @(posedge clk) begin : watch
    result_t r;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, BLANK_CHAR};
      row_now = '0;
      col_now = '0;
      fg = RESET_FG;
      bg = RESET_BG;
      awaited_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_FG: fg = pwdata[NIBBLE_W-1:0];
          REG_BG: bg = pwdata[NIBBLE_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        results_n++;
        check_result(result);
      end
      if (item_valid && !item_stall) begin
        items_n++;
        console_step(item, r);
        awaited_q.push_back(r);
      end
    end
    mismatches   <= errs;
    pending      <= awaited_q.size();
    items_seen   <= items_n;
    results_seen <= results_n;
    scrolls      <= scroll_n;
    wraps        <= wrap_n;
  end

endmodule

// File: bench/text_console_writer_top_tb.sv
module text_console_writer_top_tb;

  import tcw_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         CYCLE_LIMIT = 800000;

  logic                  clk;
  logic                  rst;
  item_t                 item;
  logic                  item_valid;
  logic                  item_stall;
  result_t               result;
  logic                  result_valid;
  logic                  result_stall;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int pending;
  int items_seen;
  int results_seen;
  int scrolls;
  int wraps;
  int cycles;
  int sent;
  int settings_used;
  bit send_calm;
  bit recv_calm;

  text_console_writer_top u_top (.*);

  text_console_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int draw_gap(bit calm);
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic item_t make_item(logic [1:0] op, logic [7:0] ch, logic [4:0] rr,
                                      logic [6:0] rc);
    item_t it;
    it.opcode    = op;
    it.char_code = ch;
    it.read_row  = rr;
    it.read_col  = rc;
    return it;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(0, 4) != 0) begin
      c = 8'($urandom_range(32, 126));
    end else begin
      c = 8'($urandom_range(0, 255));
      if (c == NEWLINE_CHAR) c = 8'd11;
    end
    return c;
  endfunction

  task automatic push_item(input item_t it);
    int gap;
    if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  task automatic send_put(input logic [7:0] ch);
    push_item(make_item(OP_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
  endtask

  task automatic send_read(input logic [4:0] rr, input logic [6:0] rc);
    push_item(make_item(OP_READ, 8'($urandom_range(0, 255)), rr, rc));
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-3:0] idx, input logic [NIBBLE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DATA_W-NIBBLE_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_colours(input logic [NIBBLE_W-1:0] f, input logic [NIBBLE_W-1:0] b);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_FG, f);
    write_reg(REG_BG, b);
    settings_used++;
  endtask

  task automatic random_traffic(input int count);
    int stop;
    int n;
    int pick;
    stop = sent + count;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 40);
        repeat (n) send_put(text_char());
        if ($urandom_range(0, 2) != 0) send_put(NEWLINE_CHAR);
      end else if (pick < 55) begin
        repeat ($urandom_range(1, 30)) send_put(NEWLINE_CHAR);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 9) == 0)
            send_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
          else
            send_read(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
        end
      end else if (pick < 85) begin
        push_item(make_item(OP_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                            7'($urandom_range(0, 127))));
      end else begin
        repeat ($urandom_range(1, 4))
          push_item(make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
      end
    end
  endtask

  initial begin : drain
    int n;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
      n = draw_gap(recv_calm);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset contents, corners, out-of-range reads, puts, newline, spare opcodes and clear
    send_read(5'd0, 7'd0);
    send_read(5'd24, 7'd79);
    send_read(5'd25, 7'd0);
    send_read(5'd0, 7'd80);
    send_read(5'd31, 7'd127);
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'h41);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
    send_read(5'd0, 7'd2);
    send_put(NEWLINE_CHAR);
    send_put(8'h55);
    send_read(5'd1, 7'd0);
    push_item(make_item(OP_SPARE, 8'hFF, 5'h1F, 7'h7F));
    push_item(make_item(OP_SPARE, 8'h00, 5'h00, 7'h00));
    push_item(make_item(OP_CLEAR, 8'hAA, 5'h15, 7'h2A));
    send_read(5'd0, 7'd0);
    send_read(5'd1, 7'd0);

    set_colours(4'h0, 4'h0);
    random_traffic(150);
    set_colours(4'hF, 4'hF);
    random_traffic(150);
    set_colours(4'h0, 4'hF);
    random_traffic(150);
    set_colours(4'hF, 4'h0);
    random_traffic(150);
    set_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    random_traffic(150);
    set_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    random_traffic(150);

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d items sent and %0d results checked over %0d colour settings",
             items_seen, results_seen, settings_used);
    $display("predictor saw %0d scrolls and %0d wraps at a full line", scrolls, wraps);
    if (mismatches + pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
